/* src/acpsf_pkg.sv */
// ============================================================================
// acpsf_pkg
// Shared types and constants for the multi-pattern PAM site finder.
// ============================================================================
`default_nettype none

package acpsf_pkg;

    // Automaton sizing.
    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 93;
    localparam int MAX_WORDS     = 256;
    localparam int FIRST_CODE    = 33;
    localparam int HIT_SAT       = 2;

    // Derived widths.
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int SYM_W      = $clog2(ALPHABET_SIZE);
    localparam int WORD_W     = $clog2(MAX_WORDS);
    localparam int WCNT_W     = $clog2(MAX_WORDS + 1);
    localparam int QPTR_W     = $clog2(MAX_NODES + 1);
    localparam int GOTO_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
    localparam int HIT_W      = 2;
    localparam int TIDX_W     = 31;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 2'd2;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_BUILD   = 2'd2,
        MODE_TEXT    = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [6:0] symbol;
        logic       word_end;
    } req_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               reverse_strand;
        logic               last_of_run;
    } rsp_t;

endpackage

`default_nettype wire

/* src/acpsf_ram.sv */
// ============================================================================
// acpsf_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module acpsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/aho_corasick_pam_site_finder_top.sv */
// ============================================================================
// aho_corasick_pam_site_finder_top
// Trie loader, breadth-first failure-link builder and text walker that reports
// forward and reverse PAM guide positions.
// ============================================================================
// A pattern character follows or creates one trie edge; a text character follows failure
// links, reads the match record of the new node and hands out its results, waiting while results are stalled.
// Build scans goto entries, pops nodes, walks failure links and merges match records.
// One request at a time; stall stays high until it is done.
// Reset and a clear request run a sweep over the goto table. No request is
// taken meanwhile, but configuration writes are.
`default_nettype none

module aho_corasick_pam_site_finder_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire acpsf_pkg::req_t                req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output acpsf_pkg::rsp_t                     rsp,
    input  wire logic                           cfg_we,
    input  wire logic [acpsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acpsf_pkg::CFG_W-1:0]     cfg_data
);

    import acpsf_pkg::*;

    typedef enum logic [23:0] {
        S_CLEAR   = 24'h000001,
        S_IDLE    = 24'h000002,
        S_INS_RD  = 24'h000004,
        S_INS_CHK = 24'h000008,
        S_WE_RD   = 24'h000010,
        S_WE_WR   = 24'h000020,
        S_BR_RD   = 24'h000040,
        S_BR_CHK  = 24'h000080,
        S_BR_NEXT = 24'h000100,
        S_BQ_POP  = 24'h000200,
        S_BQ_WT   = 24'h000400,
        S_BS_WT   = 24'h000800,
        S_BC_RD   = 24'h001000,
        S_BC_CHK  = 24'h002000,
        S_BC_NEXT = 24'h004000,
        S_F_RD    = 24'h008000,
        S_F_CHK   = 24'h010000,
        S_F_FAIL  = 24'h020000,
        S_M_SRC   = 24'h040000,
        S_M_DST   = 24'h080000,
        S_M_UPD   = 24'h100000,
        S_T_RD    = 24'h200000,
        S_T_CALC  = 24'h400000,
        S_EMIT    = 24'h800000
    } state_t;

    localparam logic [TIDX_W-1:0]  TIDX_MAX  = {TIDX_W{1'b1}};
    localparam logic [GOTO_AW-1:0] CLR_LAST  = GOTO_AW'(GOTO_DEPTH - 1);
    localparam logic [SYM_W-1:0]   SYM_LAST  = SYM_W'(ALPHABET_SIZE - 1);
    localparam logic [HIT_W-1:0]   HIT_MAX   = HIT_W'(HIT_SAT);

    // Control registers.
    state_t              state_reg, state_next;
    logic [GOTO_AW-1:0]  clr_reg, clr_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   nodes_reg, nodes_next;
    logic [WCNT_W-1:0]   words_reg, words_next;
    logic [TIDX_W-1:0]   tidx_reg, tidx_next;
    logic                built_reg, built_next;
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QPTR_W-1:0]   guard_reg, guard_next;
    logic                fret_text_reg, fret_text_next;
    logic                mret_child_reg, mret_child_next;
    logic                emit_fwd_reg, emit_fwd_next;
    logic                emit_rev_reg, emit_rev_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [7:0]          pam_length_reg, pam_length_next;
    logic [7:0]          pam_limit_reg, pam_limit_next;
    logic [TIDX_W-1:0]   text_length_reg, text_length_next;

    // Working registers.
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                wend_reg, wend_next;
    logic [NODE_W-1:0]   s_reg, s_next;
    logic [NODE_W-1:0]   fs_reg, fs_next;
    logic [NODE_W-1:0]   child_reg, child_next;
    logic [NODE_W-1:0]   fnode_reg, fnode_next;
    logic [NODE_W-1:0]   msrc_reg, msrc_next;
    logic [NODE_W-1:0]   mdst_reg, mdst_next;
    logic [HIT_W-1:0]    mcs_reg, mcs_next;
    logic [WORD_W-1:0]   mls_reg, mls_next;
    logic [TIDX_W-1:0]   i_reg, i_next;
    logic [31:0]         fwd_pos_reg, fwd_pos_next;
    logic [31:0]         rev_pos_reg, rev_pos_next;
    rsp_t                rsp_reg, rsp_next;

    // Memory ports.
    logic                goto_we;
    logic [GOTO_AW-1:0]  goto_waddr;
    logic [NODE_W-1:0]   goto_wdata;
    logic [GOTO_AW-1:0]  goto_addr;
    logic [NODE_W-1:0]   goto_rdata;
    logic [NODE_W-1:0]   goto_node;

    logic [NODE_W-1:0]   naddr;
    logic                fail_we;
    logic [NODE_W-1:0]   fail_waddr;
    logic [NODE_W-1:0]   fail_wdata;
    logic [NODE_W-1:0]   fail_rdata;
    logic                low_we;
    logic [NODE_W-1:0]   low_waddr;
    logic [WORD_W-1:0]   low_wdata;
    logic [WORD_W-1:0]   low_rdata;
    logic                hit_we;
    logic [NODE_W-1:0]   hit_waddr;
    logic [HIT_W-1:0]    hit_wdata;
    logic [HIT_W-1:0]    hit_rdata;
    logic                q_we;
    logic [NODE_W-1:0]   q_waddr;
    logic [NODE_W-1:0]   q_wdata;
    logic [NODE_W-1:0]   q_raddr;
    logic [NODE_W-1:0]   q_rdata;

    // Request decode.
    logic                req_take;
    logic                sym_ok;
    logic [SYM_W-1:0]    sym_idx;
    logic                rsp_load;

    // Text arithmetic.
    logic [33:0]         lhs_rev;
    logic [33:0]         lhs_wide;
    logic [33:0]         rhs_bound;
    logic                fwd_ok;
    logic                fwd_low;
    logic [HIT_W:0]      hit_sum;

    assign req_take  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_load  = (state_reg == S_EMIT) && (emit_fwd_reg || emit_rev_reg)
                       && (!rsp_valid_reg || !rsp_stall);

    assign sym_ok  = ({2'b00, req.symbol} >= 9'(FIRST_CODE))
                     && ({2'b00, req.symbol} < 9'(FIRST_CODE + ALPHABET_SIZE));
    assign sym_idx = SYM_W'(req.symbol - 7'(FIRST_CODE));

    // Shared goto address unit: node * alphabet + symbol.
    always_comb
    begin
        unique case (state_reg)
            S_INS_RD, S_INS_CHK: goto_node = cursor_reg;
            S_BC_RD:             goto_node = s_reg;
            S_F_RD:              goto_node = fnode_reg;
            default:             goto_node = '0;
        endcase
    end

    assign goto_addr = GOTO_AW'(goto_node) * GOTO_AW'(ALPHABET_SIZE) + GOTO_AW'(sym_reg);

    // Node table read address shared by failure, lowest-word and hit tables.
    always_comb
    begin
        unique case (state_reg)
            S_WE_RD: naddr = cursor_reg;
            S_BQ_WT: naddr = q_rdata;
            S_F_CHK: naddr = fnode_reg;
            S_M_SRC: naddr = msrc_reg;
            S_M_DST: naddr = mdst_reg;
            S_T_RD:  naddr = cur_reg;
            default: naddr = '0;
        endcase
    end

    // Bound tests for the text step.
    assign fwd_ok    = {3'b000, i_reg} >= (34'(pam_length_reg) + 34'd1);
    assign lhs_rev   = 34'(i_reg) + 34'(pam_length_reg) + 34'd3;
    assign lhs_wide  = 34'(i_reg) + 34'(pam_length_reg) + 34'd1;
    assign rhs_bound = 34'(text_length_reg) + 34'(pam_limit_reg);
    assign fwd_low   = {1'b0, low_rdata} < (words_reg >> 1);
    assign hit_sum   = {1'b0, hit_rdata} + {1'b0, mcs_reg};

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        cur_next         = cur_reg;
        cursor_next      = cursor_reg;
        nodes_next       = nodes_reg;
        words_next       = words_reg;
        tidx_next        = tidx_reg;
        built_next       = built_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        guard_next       = guard_reg;
        fret_text_next   = fret_text_reg;
        mret_child_next  = mret_child_reg;
        emit_fwd_next    = emit_fwd_reg;
        emit_rev_next    = emit_rev_reg;
        sym_next         = sym_reg;
        wend_next        = wend_reg;
        s_next           = s_reg;
        fs_next          = fs_reg;
        child_next       = child_reg;
        fnode_next       = fnode_reg;
        msrc_next        = msrc_reg;
        mdst_next        = mdst_reg;
        mcs_next         = mcs_reg;
        mls_next         = mls_reg;
        i_next           = i_reg;
        fwd_pos_next     = fwd_pos_reg;
        rev_pos_next     = rev_pos_reg;

        goto_we    = 1'b0;
        goto_waddr = goto_addr;
        goto_wdata = '0;
        fail_we    = 1'b0;
        fail_waddr = child_reg;
        fail_wdata = '0;
        low_we     = 1'b0;
        low_waddr  = mdst_reg;
        low_wdata  = mls_reg;
        hit_we     = 1'b0;
        hit_waddr  = mdst_reg;
        hit_wdata  = '0;
        q_we       = 1'b0;
        q_waddr    = NODE_W'(tail_reg);
        q_wdata    = goto_rdata;
        q_raddr    = NODE_W'(head_reg);

        unique case (state_reg)
            // Sweep the goto and hit tables back to zero.
            S_CLEAR:
            begin
                goto_we    = 1'b1;
                goto_waddr = clr_reg;
                if (clr_reg < GOTO_AW'(MAX_NODES))
                begin
                    hit_we    = 1'b1;
                    hit_waddr = NODE_W'(clr_reg);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a request and dispatch on its mode.
            S_IDLE:
            begin
                if (req_take)
                begin
                    wend_next = req.word_end;
                    unique case (req.mode)
                        MODE_CLEAR:
                        begin
                            cur_next    = '0;
                            cursor_next = '0;
                            nodes_next  = '0;
                            words_next  = '0;
                            tidx_next   = '0;
                            built_next  = 1'b0;
                            clr_next    = '0;
                            state_next  = S_CLEAR;
                        end
                        MODE_PATTERN:
                        begin
                            if (!built_reg)
                            begin
                                if (sym_ok)
                                begin
                                    sym_next   = sym_idx;
                                    state_next = S_INS_RD;
                                end
                                else if (req.word_end)
                                begin
                                    state_next = S_WE_RD;
                                end
                            end
                        end
                        MODE_BUILD:
                        begin
                            cur_next  = '0;
                            tidx_next = '0;
                            if (!built_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                sym_next   = '0;
                                state_next = S_BR_RD;
                            end
                        end
                        MODE_TEXT:
                        begin
                            if (built_reg)
                            begin
                                i_next = tidx_reg;
                                if (tidx_reg != TIDX_MAX)
                                begin
                                    tidx_next = tidx_reg + 1'b1;
                                end
                                if (!sym_ok)
                                begin
                                    cur_next = '0;
                                end
                                else
                                begin
                                    sym_next       = sym_idx;
                                    fnode_next     = cur_reg;
                                    guard_next     = '0;
                                    fret_text_next = 1'b1;
                                    state_next     = S_F_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Pattern character: follow or create the trie edge.
            S_INS_RD:
            begin
                state_next = S_INS_CHK;
            end

            S_INS_CHK:
            begin
                if (goto_rdata != '0)
                begin
                    cursor_next = goto_rdata;
                end
                else if ((QPTR_W'(nodes_reg) + 1'b1) < QPTR_W'(MAX_NODES))
                begin
                    nodes_next  = nodes_reg + 1'b1;
                    goto_we     = 1'b1;
                    goto_wdata  = nodes_reg + 1'b1;
                    cursor_next = nodes_reg + 1'b1;
                end
                state_next = wend_reg ? S_WE_RD : S_IDLE;
            end

            // Word end: record the word at the cursor node.
            S_WE_RD:
            begin
                state_next = S_WE_WR;
            end

            S_WE_WR:
            begin
                if (words_reg < WCNT_W'(MAX_WORDS))
                begin
                    if (hit_rdata == '0)
                    begin
                        low_we    = 1'b1;
                        low_waddr = cursor_reg;
                        low_wdata = WORD_W'(words_reg);
                    end
                    hit_we    = 1'b1;
                    hit_waddr = cursor_reg;
                    hit_wdata = (hit_rdata < HIT_MAX) ? hit_rdata + 1'b1 : hit_rdata;
                    words_next = words_reg + 1'b1;
                end
                cursor_next = '0;
                state_next  = S_IDLE;
            end

            // Build: children of the root fail to the root.
            S_BR_RD:
            begin
                state_next = S_BR_CHK;
            end

            S_BR_CHK:
            begin
                if ((goto_rdata != '0) && (tail_reg < QPTR_W'(MAX_NODES)))
                begin
                    fail_we         = 1'b1;
                    fail_waddr      = goto_rdata;
                    q_we            = 1'b1;
                    tail_next       = tail_reg + 1'b1;
                    mdst_next       = goto_rdata;
                    msrc_next       = '0;
                    mret_child_next = 1'b0;
                    state_next      = S_M_SRC;
                end
                else
                begin
                    state_next = S_BR_NEXT;
                end
            end

            S_BR_NEXT:
            begin
                if (sym_reg == SYM_LAST)
                begin
                    state_next = S_BQ_POP;
                end
                else
                begin
                    sym_next   = sym_reg + 1'b1;
                    state_next = S_BR_RD;
                end
            end

            // Build: pop the next node in breadth-first order.
            S_BQ_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    state_next = S_BQ_WT;
                end
                else
                begin
                    built_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_BQ_WT:
            begin
                s_next     = q_rdata;
                head_next  = head_reg + 1'b1;
                sym_next   = '0;
                state_next = S_BS_WT;
            end

            S_BS_WT:
            begin
                fs_next    = fail_rdata;
                state_next = S_BC_RD;
            end

            // Build: scan the children of the popped node.
            S_BC_RD:
            begin
                state_next = S_BC_CHK;
            end

            S_BC_CHK:
            begin
                if (goto_rdata == '0)
                begin
                    state_next = S_BC_NEXT;
                end
                else
                begin
                    if (tail_reg < QPTR_W'(MAX_NODES))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                    child_next     = goto_rdata;
                    fnode_next     = fs_reg;
                    guard_next     = '0;
                    fret_text_next = 1'b0;
                    state_next     = S_F_RD;
                end
            end

            S_BC_NEXT:
            begin
                if (sym_reg == SYM_LAST)
                begin
                    state_next = S_BQ_POP;
                end
                else
                begin
                    sym_next   = sym_reg + 1'b1;
                    state_next = S_BC_RD;
                end
            end

            // Failure walk until the symbol has an edge or the root is reached.
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end

            S_F_CHK:
            begin
                if ((fnode_reg != '0) && (goto_rdata == '0)
                    && (guard_reg < QPTR_W'(MAX_NODES)))
                begin
                    state_next = S_F_FAIL;
                end
                else if (fret_text_reg)
                begin
                    cur_next   = goto_rdata;
                    state_next = S_T_RD;
                end
                else
                begin
                    fail_we         = 1'b1;
                    fail_waddr      = child_reg;
                    fail_wdata      = goto_rdata;
                    msrc_next       = goto_rdata;
                    mdst_next       = child_reg;
                    mret_child_next = 1'b1;
                    state_next      = S_M_SRC;
                end
            end

            S_F_FAIL:
            begin
                fnode_next = fail_rdata;
                guard_next = guard_reg + 1'b1;
                state_next = S_F_RD;
            end

            // Merge the match record of the source node into the destination.
            S_M_SRC:
            begin
                state_next = S_M_DST;
            end

            S_M_DST:
            begin
                mcs_next   = hit_rdata;
                mls_next   = low_rdata;
                state_next = S_M_UPD;
            end

            S_M_UPD:
            begin
                if (mcs_reg != '0)
                begin
                    if ((hit_rdata == '0) || (mls_reg < low_rdata))
                    begin
                        low_we = 1'b1;
                    end
                    hit_we    = 1'b1;
                    hit_wdata = (hit_sum > (HIT_W + 1)'(HIT_SAT)) ? HIT_MAX
                                                                 : HIT_W'(hit_sum);
                end
                state_next = mret_child_reg ? S_BC_NEXT : S_BR_NEXT;
            end

            // Text: read the match record of the new node.
            S_T_RD:
            begin
                state_next = S_T_CALC;
            end

            S_T_CALC:
            begin
                fwd_pos_next = 32'(i_reg) - 32'(pam_length_reg) - 32'd1;
                rev_pos_next = 32'(pam_limit_reg) - 32'd1 - 32'(i_reg);
                if (hit_rdata == '0)
                begin
                    emit_fwd_next = 1'b0;
                    emit_rev_next = 1'b0;
                end
                else if (fwd_low)
                begin
                    emit_fwd_next = fwd_ok;
                    emit_rev_next = (hit_rdata >= HIT_MAX) && (lhs_rev <= rhs_bound);
                end
                else if (hit_rdata == 2'd1)
                begin
                    emit_fwd_next = 1'b0;
                    emit_rev_next = (lhs_rev <= rhs_bound);
                end
                else
                begin
                    emit_fwd_next = 1'b0;
                    emit_rev_next = (lhs_wide <= rhs_bound);
                end
                state_next = S_EMIT;
            end

            // Hand the results to the output register in order.
            S_EMIT:
            begin
                if (!emit_fwd_reg && !emit_rev_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (rsp_load)
                begin
                    if (emit_fwd_reg)
                    begin
                        emit_fwd_next = 1'b0;
                    end
                    else
                    begin
                        emit_rev_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            if (emit_fwd_reg)
            begin
                rsp_next.position       = fwd_pos_reg;
                rsp_next.reverse_strand = 1'b0;
                rsp_next.last_of_run    = !emit_rev_reg;
            end
            else
            begin
                rsp_next.position       = rev_pos_reg;
                rsp_next.reverse_strand = 1'b1;
                rsp_next.last_of_run    = 1'b1;
            end
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Configuration writes.
    always_comb
    begin
        pam_length_next  = pam_length_reg;
        pam_limit_next   = pam_limit_reg;
        text_length_next = text_length_reg;
        if (cfg_we)
        begin
            priority if (cfg_index == CFG_PAM_LENGTH)
            begin
                pam_length_next = cfg_data[7:0];
            end
            else if (cfg_index == CFG_PAM_LIMIT)
            begin
                pam_limit_next = cfg_data[7:0];
            end
            else if (cfg_index == CFG_TEXT_LENGTH)
            begin
                text_length_next = cfg_data[TIDX_W-1:0];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            cur_reg         <= '0;
            cursor_reg      <= '0;
            nodes_reg       <= '0;
            words_reg       <= '0;
            tidx_reg        <= '0;
            built_reg       <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            guard_reg       <= '0;
            fret_text_reg   <= 1'b0;
            mret_child_reg  <= 1'b0;
            emit_fwd_reg    <= 1'b0;
            emit_rev_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            pam_length_reg  <= 8'd3;
            pam_limit_reg   <= 8'd23;
            text_length_reg <= TIDX_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            cur_reg         <= cur_next;
            cursor_reg      <= cursor_next;
            nodes_reg       <= nodes_next;
            words_reg       <= words_next;
            tidx_reg        <= tidx_next;
            built_reg       <= built_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            guard_reg       <= guard_next;
            fret_text_reg   <= fret_text_next;
            mret_child_reg  <= mret_child_next;
            emit_fwd_reg    <= emit_fwd_next;
            emit_rev_reg    <= emit_rev_next;
            rsp_valid_reg   <= rsp_valid_next;
            pam_length_reg  <= pam_length_next;
            pam_limit_reg   <= pam_limit_next;
            text_length_reg <= text_length_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        wend_reg    <= wend_next;
        s_reg       <= s_next;
        fs_reg      <= fs_next;
        child_reg   <= child_next;
        fnode_reg   <= fnode_next;
        msrc_reg    <= msrc_next;
        mdst_reg    <= mdst_next;
        mcs_reg     <= mcs_next;
        mls_reg     <= mls_next;
        i_reg       <= i_next;
        fwd_pos_reg <= fwd_pos_next;
        rev_pos_reg <= rev_pos_next;
        rsp_reg     <= rsp_next;
    end

    // Table memories.
    acpsf_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
        .clk   (clk),
        .we    (goto_we),
        .waddr (goto_waddr),
        .wdata (goto_wdata),
        .raddr (goto_addr),
        .rdata (goto_rdata)
    );

    acpsf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .clk   (clk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (naddr),
        .rdata (fail_rdata)
    );

    acpsf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_NODES)) u_low (
        .clk   (clk),
        .we    (low_we),
        .waddr (low_waddr),
        .wdata (low_wdata),
        .raddr (naddr),
        .rdata (low_rdata)
    );

    acpsf_ram #(.WIDTH(HIT_W), .DEPTH(MAX_NODES)) u_hit (
        .clk   (clk),
        .we    (hit_we),
        .waddr (hit_waddr),
        .wdata (hit_wdata),
        .raddr (naddr),
        .rdata (hit_rdata)
    );

    acpsf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

endmodule

`default_nettype wire

/* src/acpsf_checker.sv */
// ============================================================================
// acpsf_checker
// Port-level checks for the PAM site finder, bound to the top level.
// ============================================================================
`default_nettype none

module acpsf_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_stall,
    input wire acpsf_pkg::req_t req,
    input wire logic            rsp_valid,
    input wire logic            rsp_stall,
    input wire acpsf_pkg::rsp_t rsp
);

    import acpsf_pkg::*;

    // A stalled result stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result changed while stalled");

    // A clear request starts the sweep, so no request is taken next cycle.
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.mode == MODE_CLEAR) |=> req_stall)
        else $error("request taken right after a clear");

    // Only a forward result can be followed by another of the same character.
    a_last_rev: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last_of_run |-> !rsp.reverse_strand)
        else $error("reverse result not last of its run");

endmodule

bind aho_corasick_pam_site_finder_top acpsf_checker u_acpsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
